/* hw/rtl/programmable_tone_generator_macros.svh */
// Assertion macros used by the tone generator back end.
`ifndef PROGRAMMABLE_TONE_GENERATOR_MACROS_SVH
`define PROGRAMMABLE_TONE_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define PTG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PTG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define PTG_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PTG_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/ptg_pkg.sv */
package ptg_pkg;

  // field widths
  localparam int SCALE_W    = 16;
  localparam int OFFSET_W   = 8;
  localparam int CMD_W      = 2;
  localparam int DIGIT_W    = 4;
  localparam int SEG_W      = 8;
  localparam int SEG_FIELDS = 4;

  // defaults
  localparam int DIGIT_COUNT_DEF = 4;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 16'd46080;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd30;
  localparam logic [SCALE_W-1:0]  TOP_COUNT    = 16'hFFFF;
  localparam logic [SEG_W-1:0]    SEG_BLANK    = 8'hFF;
  localparam logic [DIGIT_W-1:0]  DIGIT_MAX    = 4'd9;

  // input commands
  localparam logic [CMD_W-1:0] CMD_DIGIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUTTON = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  // classified operations
  localparam logic [1:0] OP_DIGIT  = 2'd0;
  localparam logic [1:0] OP_BUTTON = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // register selects (paddr[2])
  localparam logic REG_SCALE  = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [DIGIT_W-1:0] digit;
  } op_t;

  typedef struct packed {
    logic [SCALE_W-1:0]  scale;
    logic [OFFSET_W-1:0] offset;
  } cfg_t;

  typedef struct packed {
    logic               done;
    logic [SCALE_W-1:0] quotient;
  } div_rsp_t;

  // packed so that buzzer sits in the lowest bit
  typedef struct packed {
    logic               freq_error;
    logic [SCALE_W-1:0] reload_value;
    logic [SEG_W-1:0]   seg_ones;
    logic [SEG_W-1:0]   seg_tens;
    logic [SEG_W-1:0]   seg_hundreds;
    logic [SEG_W-1:0]   seg_thousands;
    logic               tone_on;
    logic               buzzer;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

  // active-low seven-segment pattern, digits above nine show as nine
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0:    p = 8'hC0;
      4'd1:    p = 8'hF9;
      4'd2:    p = 8'hA4;
      4'd3:    p = 8'hB0;
      4'd4:    p = 8'h99;
      4'd5:    p = 8'h92;
      4'd6:    p = 8'h82;
      4'd7:    p = 8'hF8;
      4'd8:    p = 8'h80;
      default: p = 8'h98;
    endcase
    return p;
  endfunction

endpackage

/* hw/rtl/ptg_front.sv */
module ptg_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [1:0] command, [5:2] digit
  output logic               op_valid,
  input  logic               op_ready,
  output ptg_pkg::op_t       op
);
  import ptg_pkg::*;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CMD_W-1:0]   command;
  logic [DIGIT_W-1:0] digit;
  op_t                op_in;
  op_t                qmem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;

  assign command = s_tdata[CMD_W-1:0];
  assign digit   = s_tdata[CMD_W+DIGIT_W-1:CMD_W];

  // classify the command, clamp the digit
  always_comb begin
    op_in.digit = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
    case (command)
      CMD_DIGIT:  op_in.kind = OP_DIGIT;
      CMD_BUTTON: op_in.kind = OP_BUTTON;
      CMD_TICK:   op_in.kind = OP_TICK;
      default:    op_in.kind = OP_NONE;
    endcase
  end

  assign s_tready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign op_valid = (count != '0);
  assign pop      = op_valid && op_ready;
  assign op       = qmem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= op_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/ptg_div.sv */
module ptg_div #(
  parameter int DIV_W = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ptg_pkg::SCALE_W-1:0] dividend,
  input  logic [DIV_W-1:0]            divisor,
  output ptg_pkg::div_rsp_t           rsp
);
  import ptg_pkg::*;

  localparam int CNT_W = $clog2(SCALE_W + 1);

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_W-1:0]   rem;
  logic [DIV_W-1:0]   dvs;
  logic [SCALE_W-1:0] quo;
  logic [DIV_W:0]     shifted;
  logic [DIV_W:0]     diff;
  logic               fits;

  // one quotient bit per cycle, restoring
  assign shifted = {rem, quo[SCALE_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo <= {quo[SCALE_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SCALE_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* hw/rtl/ptg_back.sv */
`include "programmable_tone_generator_macros.svh"

module ptg_back #(
  parameter int DIGIT_COUNT = ptg_pkg::DIGIT_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ptg_pkg::cfg_t     cfg,
  input  logic              op_valid,
  output logic              op_ready,
  input  ptg_pkg::op_t      op,
  output logic              m_tvalid,
  input  logic              m_tready,
  output ptg_pkg::result_t  m_result
);
  import ptg_pkg::*;

  localparam int POS_W  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int FREQ_W = $clog2(10 ** DIGIT_COUNT);

  localparam logic [1:0] S_RUN  = 2'd0;
  localparam logic [1:0] S_FREQ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [DIGIT_W-1:0] digit_store      [DIGIT_COUNT];
  logic [DIGIT_W-1:0] digit_store_next [DIGIT_COUNT];
  logic [POS_W-1:0]   digit_pos;
  logic [POS_W-1:0]   digit_pos_next;
  logic [SCALE_W-1:0] reload;
  logic [SCALE_W-1:0] reload_next;
  logic [SCALE_W-1:0] tick_cnt;
  logic [SCALE_W-1:0] tick_cnt_next;
  logic [SCALE_W-1:0] tick_inc;
  logic               running;
  logic               running_next;
  logic               buzzer_level;
  logic               buzzer_next;
  logic               error_flag;
  logic               error_next;
  logic               out_valid;
  logic               slot_free;
  logic               op_pop;
  logic               out_load;
  logic               last_place;
  logic               div_start;
  logic [FREQ_W-1:0]  freq;
  logic [SCALE_W-1:0] quot10;
  div_rsp_t           div_rsp;
  logic [SEG_W-1:0]   seg [SEG_FIELDS];

  assign slot_free  = !out_valid || m_tready;
  assign op_pop     = (state == S_RUN) && op_valid && slot_free;
  assign op_ready   = op_pop;
  assign last_place = (digit_pos == POS_W'(DIGIT_COUNT - 1));
  assign tick_inc   = tick_cnt + SCALE_W'(1);
  assign quot10     = (div_rsp.quotient << 3) + (div_rsp.quotient << 1);

  // frequency from the stored decimal places, most significant first
  always_comb begin
    freq = '0;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      freq = (freq << 3) + (freq << 1) + FREQ_W'(digit_store[k]);
    end
  end

  // sequencer and next state
  always_comb begin
    state_next     = state;
    digit_pos_next = digit_pos;
    reload_next    = reload;
    tick_cnt_next  = tick_cnt;
    running_next   = running;
    buzzer_next    = buzzer_level;
    error_next     = error_flag;
    div_start      = 1'b0;
    out_load       = 1'b0;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      digit_store_next[k] = digit_store[k];
    end
    case (state)
      S_RUN: begin
        if (op_pop) begin
          out_load = 1'b1;
          case (op.kind)
            OP_DIGIT: begin
              digit_store_next[digit_pos] = op.digit;
              if (last_place) begin
                digit_pos_next = '0;
                state_next     = S_FREQ;
                out_load       = 1'b0;
              end else begin
                digit_pos_next = digit_pos + POS_W'(1);
              end
            end
            OP_BUTTON: begin
              running_next = !running;
            end
            OP_TICK: begin
              if (running) begin
                if (tick_inc == '0) begin
                  tick_cnt_next = reload;
                  buzzer_next   = !buzzer_level;
                end else begin
                  tick_cnt_next = tick_inc;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FREQ: begin
        if (freq == '0) begin
          error_next = 1'b1;
          state_next = S_EMIT;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          reload_next = TOP_COUNT - quot10 + SCALE_W'(cfg.offset);
          error_next  = 1'b0;
          state_next  = S_EMIT;
        end
      end
      default: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = S_RUN;
        end
      end
    endcase
  end

  ptg_div #(
    .DIV_W (FREQ_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cfg.scale),
    .divisor  (freq),
    .rsp      (div_rsp)
  );

  // display patterns of the updated places
  for (genvar k = 0; k < SEG_FIELDS; k++) begin : g_seg
    if (k < DIGIT_COUNT) begin : g_shown
      assign seg[k] = seg_of(digit_store_next[k]);
    end else begin : g_blank
      assign seg[k] = SEG_BLANK;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_RUN;
      digit_pos    <= '0;
      reload       <= '0;
      tick_cnt     <= '0;
      running      <= 1'b0;
      buzzer_level <= 1'b0;
      error_flag   <= 1'b0;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        digit_store[k] <= '0;
      end
    end else begin
      state        <= state_next;
      digit_pos    <= digit_pos_next;
      reload       <= reload_next;
      tick_cnt     <= tick_cnt_next;
      running      <= running_next;
      buzzer_level <= buzzer_next;
      error_flag   <= error_next;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        digit_store[k] <= digit_store_next[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_result.buzzer        <= buzzer_next;
      m_result.tone_on       <= running_next;
      m_result.seg_thousands <= seg[0];
      m_result.seg_hundreds  <= seg[1];
      m_result.seg_tens      <= seg[2];
      m_result.seg_ones      <= seg[3];
      m_result.reload_value  <= reload_next;
      m_result.freq_error    <= error_next;
    end
  end

  assign m_tvalid = out_valid;

  // checks
  `PTG_ASSERT_IMP(a_pop_only_in_run, clk, rst, op_pop, state == S_RUN)
  `PTG_ASSERT_IMP(a_done_only_in_div, clk, rst, div_rsp.done, state == S_DIV)
  `PTG_ASSERT_NXT(a_buzzer_only_on_tick, clk, rst, !(op_pop && op.kind == OP_TICK), $stable(buzzer_level))
  `PTG_ASSERT_NXT(a_out_held_on_stall, clk, rst, out_valid && !m_tready, out_valid && $stable(m_result))

endmodule

/* hw/rtl/programmable_tone_generator.sv */
// Channel   Dir  Handshake                       Payload
// s_*       in   s_tvalid / s_tready             s_tdata: command, digit
// m_*       out  m_tvalid / m_tready             m_tdata: one result item
// APB       in   psel, penable, pwrite, pready   paddr 0 timer_scale, 4 reload_offset
//
// Each item gives exactly one result item; a tick, button or ordinary digit
// is handled in the back end's run state. The digit that completes an entry holds
// the back end while it forms the frequency, runs the serial divider (16 quotient
// bits, then a done flag) and delivers the result; a zero frequency skips the
// divider. A two-entry queue keeps accepting items meanwhile until it is full.
// The output register holds a result until m_tready takes it. Reset is
// synchronous and active high; it clears all control state.
module programmable_tone_generator #(
  parameter int DIGIT_COUNT = ptg_pkg::DIGIT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // [1:0] command, [5:2] digit
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [0] buzzer, [1] tone_on, [9:2] seg_thousands, [17:10] seg_hundreds,
  // [25:18] seg_tens, [33:26] seg_ones, [49:34] reload_value, [50] freq_error
  output logic [ptg_pkg::TDATA_W-1:0] m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ptg_pkg::*;

  cfg_t    cfg;
  logic    cfg_write;
  logic    op_valid;
  logic    op_ready;
  op_t     op;
  result_t result;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale  <= SCALE_RESET;
      cfg.offset <= OFFSET_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_SCALE:  cfg.scale  <= pwdata[SCALE_W-1:0];
        REG_OFFSET: cfg.offset <= pwdata[OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      REG_SCALE:  prdata = {{(32-SCALE_W){1'b0}}, cfg.scale};
      REG_OFFSET: prdata = {{(32-OFFSET_W){1'b0}}, cfg.offset};
      default:    prdata = '0;
    endcase
  end

  ptg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  ptg_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_result (result)
  );

  assign m_tdata = {{(TDATA_W-RESULT_W){1'b0}}, result};

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ptg_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASES       = 5;
  localparam int RAND_ITEMS   = 146;
  localparam int DIR_ROWS_N   = 22;
  localparam int TAIL_CYCLES  = 40;

  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
  localparam logic [2:0]       ADDR_SCALE  = 3'd0;
  localparam logic [2:0]       ADDR_OFFSET = 3'd4;

  localparam logic [SEG_W-1:0] SEG_CODE [0:9] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h98
  };

  // status right after reset, and after an all-zero entry
  localparam result_t RES_RESET = '{freq_error: 1'b0, reload_value: 16'h0000,
    seg_ones: 8'hC0, seg_tens: 8'hC0, seg_hundreds: 8'hC0, seg_thousands: 8'hC0,
    tone_on: 1'b0, buzzer: 1'b0};
  localparam result_t RES_ZERO_FREQ = '{freq_error: 1'b1, reload_value: 16'h0000,
    seg_ones: 8'hC0, seg_tens: 8'hC0, seg_hundreds: 8'hC0, seg_thousands: 8'hC0,
    tone_on: 1'b0, buzzer: 1'b0};

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [DIGIT_W-1:0] dig;
    logic               typed;
    result_t            res;
  } dir_row_t;

  // directed rows; typed results only where obvious
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{CMD_TICK,   4'd0,  1'b1, RES_RESET},      // tick while stopped
    '{CMD_UNUSED, 4'd15, 1'b1, RES_RESET},      // unused command
    '{CMD_DIGIT,  4'd0,  1'b1, RES_RESET},
    '{CMD_DIGIT,  4'd0,  1'b1, RES_RESET},
    '{CMD_DIGIT,  4'd0,  1'b1, RES_RESET},
    '{CMD_DIGIT,  4'd0,  1'b1, RES_ZERO_FREQ},  // frequency zero
    '{CMD_DIGIT,  4'd15, 1'b0, '0},             // clamped to nine
    '{CMD_DIGIT,  4'd9,  1'b0, '0},
    '{CMD_DIGIT,  4'd10, 1'b0, '0},
    '{CMD_DIGIT,  4'd9,  1'b0, '0},             // 9999, clears error
    '{CMD_DIGIT,  4'd0,  1'b0, '0},
    '{CMD_DIGIT,  4'd0,  1'b0, '0},
    '{CMD_DIGIT,  4'd0,  1'b0, '0},
    '{CMD_DIGIT,  4'd1,  1'b0, '0},             // frequency one
    '{CMD_DIGIT,  4'd5,  1'b0, '0},             // partial entry, old digits stay
    '{CMD_BUTTON, 4'd15, 1'b0, '0},
    '{CMD_TICK,   4'd3,  1'b0, '0},
    '{CMD_TICK,   4'd12, 1'b0, '0},
    '{CMD_TICK,   4'd0,  1'b0, '0},
    '{CMD_BUTTON, 4'd0,  1'b0, '0},
    '{CMD_TICK,   4'd7,  1'b0, '0},             // stopped again
    '{CMD_BUTTON, 4'd8,  1'b0, '0}
  };

  localparam logic [SCALE_W-1:0]  PH_SCALE  [PHASES] = '{
    16'd46080, 16'd65535, 16'd1, 16'd0, 16'd12345
  };
  localparam logic [OFFSET_W-1:0] PH_OFFSET [PHASES] = '{
    8'd30, 8'd255, 8'd0, 8'd200, 8'd128
  };

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata  = 8'h00;  // [1:0] command, [5:2] digit
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // [0] buzzer, [1] tone_on, [9:2] seg_thousands, [17:10] seg_hundreds,
  // [25:18] seg_tens, [33:26] seg_ones, [49:34] reload_value, [50] freq_error
  logic [TDATA_W-1:0]  m_tdata;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [2:0]          paddr    = 3'd0;
  logic [31:0]         pwdata   = 32'd0;
  logic [31:0]         prdata;
  logic                pready;

  // predictor state and configuration
  logic [DIGIT_W-1:0]  key_digits [DIGIT_COUNT_DEF];
  int                  key_pos;
  logic [SCALE_W-1:0]  tone_reload;
  logic [SCALE_W-1:0]  tone_count;
  bit                  tone_run;
  bit                  tone_level;
  bit                  tone_err;
  logic [SCALE_W-1:0]  cur_scale;
  logic [OFFSET_W-1:0] cur_offset;

  result_t             tone_status_q [$];
  int                  mismatches  = 0;
  int                  sent_items;
  int                  cycle_count = 0;
  bit                  hold_req    = 1'b0;
  bit                  hold_active = 1'b0;
  bit                  no_idle_s   = 1'b0;
  bit                  no_idle_m   = 1'b0;

  programmable_tone_generator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // advance the tone generator by one item, return its status
  function automatic result_t tone_step(input logic [CMD_W-1:0] cmd,
                                        input logic [DIGIT_W-1:0] dig);
    result_t     r;
    int unsigned freq;
    int unsigned quot;
    logic [DIGIT_W-1:0] d;
    d = (dig > DIGIT_MAX) ? DIGIT_MAX : dig;
    case (cmd)
      CMD_DIGIT: begin
        key_digits[key_pos] = d;
        if (key_pos == DIGIT_COUNT_DEF - 1) begin
          key_pos = 0;
          freq = 0;
          for (int k = 0; k < DIGIT_COUNT_DEF; k++)
            freq = freq * 10 + key_digits[k];
          if (freq == 0) begin
            tone_err = 1'b1;
          end else begin
            tone_err = 1'b0;
            quot = cur_scale / freq;
            tone_reload = 16'(32'hFFFF - quot * 10 + cur_offset);
          end
        end else begin
          key_pos++;
        end
      end
      CMD_BUTTON: tone_run = !tone_run;
      CMD_TICK: begin
        if (tone_run) begin
          tone_count = tone_count + 16'd1;
          if (tone_count == 16'd0) begin
            tone_count = tone_reload;
            tone_level = !tone_level;
          end
        end
      end
      default: ;
    endcase
    r.buzzer        = tone_level;
    r.tone_on       = tone_run;
    r.seg_thousands = SEG_CODE[key_digits[0]];
    r.seg_hundreds  = SEG_CODE[key_digits[1]];
    r.seg_tens      = SEG_CODE[key_digits[2]];
    r.seg_ones      = SEG_CODE[key_digits[3]];
    r.reload_value  = tone_reload;
    r.freq_error    = tone_err;
    return r;
  endfunction

  function automatic int pick_gap();
    if (hold_active || no_idle_s)
      return 0;
    return $urandom_range(0, 13);
  endfunction

  // offer one item, wait for it to be taken, queue its expected status
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DIGIT_W-1:0] dig,
                           input int gap, input bit typed, input result_t res);
    result_t p;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, dig, cmd};
    do @(posedge clk); while (!s_tready);
    p = tone_step(cmd, dig);
    tone_status_q.push_back(typed ? res : p);
    sent_items++;
  endtask

  task automatic send_rand(input logic [CMD_W-1:0] cmd, input logic [DIGIT_W-1:0] dig);
    if ($urandom_range(0, 39) == 0)
      no_idle_s = !no_idle_s;
    send_item(cmd, dig, pick_gap(), 1'b0, '0);
  endtask

  function automatic logic [DIGIT_W-1:0] rand_digit();
    if ($urandom_range(0, 5) == 0)
      return DIGIT_W'($urandom_range(10, 15));
    return DIGIT_W'($urandom_range(0, 9));
  endfunction

  // random traffic: mostly tick runs and complete entries, some noise
  task automatic random_items(input int target);
    int  pick;
    int  n;
    bit  zero_entry;
    sent_items = 0;
    while (sent_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        zero_entry = ($urandom_range(0, 19) == 0);
        n = DIGIT_COUNT_DEF - key_pos;
        repeat (n) send_rand(CMD_DIGIT, zero_entry ? 4'd0 : rand_digit());
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 8)) send_rand(CMD_TICK, DIGIT_W'($urandom));
      end else if (pick < 80) begin
        send_rand(CMD_BUTTON, DIGIT_W'($urandom));
      end else if (pick < 86) begin
        send_rand(CMD_UNUSED, DIGIT_W'($urandom));
      end else begin
        send_rand(CMD_DIGIT, rand_digit());
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (tone_status_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // read back a register and compare with what was written
  task automatic apb_check(input logic [2:0] addr, input logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d read: expected %h, got %h", addr, want, got);
    end
  endtask

  task automatic set_config(input logic [SCALE_W-1:0] scale,
                            input logic [OFFSET_W-1:0] offset);
    apb_write(ADDR_SCALE, 32'(scale));
    apb_write(ADDR_OFFSET, 32'(offset));
    cur_scale  = scale;
    cur_offset = offset;
    apb_check(ADDR_SCALE, 32'(scale));
    apb_check(ADDR_OFFSET, 32'(offset));
  endtask

  // result side: random stalls, one long hold-off, compare each item
  initial begin
    int      stall;
    int      hold_cnt;
    result_t got;
    result_t want;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        m_tready   <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        hold_active = 1'b0;
      end
      if ($urandom_range(0, 39) == 0)
        no_idle_m = !no_idle_m;
      stall = no_idle_m ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = result_t'(m_tdata[RESULT_W-1:0]);
      if (tone_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item %h", got);
      end else begin
        want = tone_status_q.pop_front();
        if (got.buzzer !== want.buzzer || got.tone_on !== want.tone_on ||
            got.seg_thousands !== want.seg_thousands ||
            got.seg_hundreds !== want.seg_hundreds ||
            got.seg_tens !== want.seg_tens || got.seg_ones !== want.seg_ones ||
            got.reload_value !== want.reload_value ||
            got.freq_error !== want.freq_error) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch expected: buz %0d on %0d seg %h %h %h %h reload %h err %0d",
                     want.buzzer, want.tone_on, want.seg_thousands, want.seg_hundreds,
                     want.seg_tens, want.seg_ones, want.reload_value, want.freq_error);
            $display("         actual:   buz %0d on %0d seg %h %h %h %h reload %h err %0d",
                     got.buzzer, got.tone_on, got.seg_thousands, got.seg_hundreds,
                     got.seg_tens, got.seg_ones, got.reload_value, got.freq_error);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // main sequence
  initial begin
    for (int k = 0; k < DIGIT_COUNT_DEF; k++)
      key_digits[k] = '0;
    key_pos     = 0;
    tone_reload = '0;
    tone_count  = '0;
    tone_run    = 1'b0;
    tone_level  = 1'b0;
    tone_err    = 1'b0;
    cur_scale   = SCALE_RESET;
    cur_offset  = OFFSET_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < PHASES; ph++) begin
      set_config(PH_SCALE[ph], PH_OFFSET[ph]);
      if (ph == 0) begin
        for (int r = 0; r < DIR_ROWS_N; r++)
          send_item(DIR_ROWS[r].cmd, DIR_ROWS[r].dig, pick_gap(),
                    DIR_ROWS[r].typed, DIR_ROWS[r].res);
      end
      if (ph == 1)
        hold_req = 1'b1;
      random_items(RAND_ITEMS);
      drain();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && tone_status_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ptg_pkg.sv
hw/rtl/ptg_front.sv
hw/rtl/ptg_div.sv
hw/rtl/ptg_back.sv
hw/rtl/programmable_tone_generator.sv
test/tb_top.sv
